// ===== sv/hptm_pkg.sv =====
`default_nettype none
package hptm_pkg;

  localparam int unsigned NumCh = 4;
  // Widest quotient and fixed-point value over the supported fraction widths.
  localparam int unsigned MaxMW = 25;
  localparam int unsigned RemW = 55;

  typedef struct packed {
    logic              zero;
    logic              full;
    logic [RemW-1:0]   rem;
    logic [RemW-1:0]   den;
    logic [MaxMW-1:0]  q;
  } div_t;

  typedef div_t [NumCh-1:0] div_pix_t;

  typedef struct packed {
    logic [MaxMW-1:0] m;
    logic [7:0]       k;
  } srch_t;

  typedef srch_t [NumCh-1:0] srch_pix_t;

  typedef logic [255:0][MaxMW-1:0] thr_tab_t;

  // Smallest fixed-point value M with M^5 * 255^11 >= k^11 * 2^(5f), for every code k.
  function automatic thr_tab_t thr_table(input int unsigned f);
    logic [255:0] c;
    logic [255:0] lhs;
    logic [255:0] p;
    logic [MaxMW-1:0] lo;
    logic [MaxMW-1:0] hi;
    logic [MaxMW-1:0] mid;
    thr_tab_t t;
    c = 256'd1;
    for (int i = 0; i < 11; i++) c = c * 256'd255;
    for (int j = 0; j < 256; j++) begin
      lhs = 256'd1;
      for (int i = 0; i < 11; i++) lhs = lhs * 256'(j);
      lhs = lhs << (5 * f);
      lo = '0;
      hi = MaxMW'(1) << f;
      for (int it = 0; it < 27; it++) begin
        if (lo < hi) begin
          mid = MaxMW'(((MaxMW+1)'(lo) + (MaxMW+1)'(hi)) >> 1);
          p = 256'd1;
          for (int i = 0; i < 5; i++) p = p * 256'(mid);
          p = p * c;
          if (p >= lhs) hi = mid;
          else lo = mid + MaxMW'(1);
        end
      end
      t[j] = lo;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== sv/hptm_decode.sv =====
`default_nettype none
module hptm_decode
  import hptm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire logic [NumCh-1:0][31:0]  bits_i,
  output logic                         valid_o,
  input  wire logic                    ready_i,
  output div_pix_t                     data_o
);

  logic     valid_q;
  div_pix_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    logic [7:0]        ex;
    logic [22:0]       fr;
    logic [23:0]       mant;
    logic signed [9:0] e;
    logic [RemW-1:0]   a;
    logic [5:0]        nsh;
    for (int c = 0; c < NumCh; c++) begin
      ex   = bits_i[c][30:23];
      fr   = bits_i[c][22:0];
      mant = {(ex != 8'd0), fr};
      e    = (ex != 8'd0) ? ($signed({2'b00, ex}) - 10'sd150) : -10'sd149;
      a    = RemW'(mant) << e[4:0];
      nsh  = 6'(-e);
      data_d[c].zero = 1'b0;
      data_d[c].full = 1'b0;
      data_d[c].rem  = '0;
      data_d[c].den  = RemW'(1);
      data_d[c].q    = '0;
      if (ex == 8'hFF) begin
        data_d[c].full = (fr == 23'd0) && !bits_i[c][31];
        data_d[c].zero = !data_d[c].full;
      end else if (bits_i[c][31]) begin
        data_d[c].zero = 1'b1;
      end else if (e > 10'sd30) begin
        data_d[c].full = 1'b1;
      end else if (e >= 10'sd0) begin
        data_d[c].rem = a;
        data_d[c].den = a + RemW'(1);
      end else if (e < -10'sd50) begin
        data_d[c].zero = 1'b1;
      end else begin
        data_d[c].rem = RemW'(mant);
        data_d[c].den = RemW'(mant) + (RemW'(1) << nsh);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hptm_div_cell.sv =====
`default_nettype none
module hptm_div_cell
  import hptm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire div_pix_t data_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output div_pix_t      data_o
);

  logic     valid_q;
  div_pix_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // One restoring division step per channel: one quotient bit per cell.
  always_comb begin
    logic [RemW:0] r2;
    logic          ge;
    logic [RemW:0] nr;
    for (int c = 0; c < NumCh; c++) begin
      r2 = {data_i[c].rem, 1'b0};
      ge = r2 >= {1'b0, data_i[c].den};
      nr = ge ? (r2 - {1'b0, data_i[c].den}) : r2;
      data_d[c]     = data_i[c];
      data_d[c].rem = nr[RemW-1:0];
      data_d[c].q   = {data_i[c].q[MaxMW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hptm_search_cell.sv =====
`default_nettype none
module hptm_search_cell
  import hptm_pkg::*;
#(
  parameter int unsigned Step = 128,
  parameter thr_tab_t    Thr  = '0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire srch_pix_t data_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output srch_pix_t      data_o
);

  logic      valid_q;
  srch_pix_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // One bit of the code is decided per cell against the constant threshold table.
  always_comb begin
    logic [7:0] cand;
    for (int c = 0; c < NumCh; c++) begin
      cand      = data_i[c].k | 8'(Step);
      data_d[c] = data_i[c];
      if (Thr[cand] <= data_i[c].m) data_d[c].k = cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hdr_pixel_tone_map.sv =====
// Throughput: one item per cycle while out_ready_i is high; every cell holds one item
// and hands it on each cycle unless stalled. The pipeline is made of the decode cell,
// the divider chain (one quotient bit per cell, INTERNAL_FRACTION_BITS + 1 cells) and
// the eight-cell code search. A full cell stalls only when its successor cannot take an
// item. Reset (async, active low) empties all cells and sets has_alpha to 1.
`default_nettype none
module hdr_pixel_tone_map
  import hptm_pkg::*;
#(
  parameter int unsigned INTERNAL_FRACTION_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] red_bits_i,
  input  wire logic [31:0] green_bits_i,
  input  wire logic [31:0] blue_bits_i,
  input  wire logic [31:0] alpha_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic [7:0]       alpha_out_o
);

  localparam int unsigned F        = INTERNAL_FRACTION_BITS;
  localparam int unsigned DivCells = F + 1;
  localparam thr_tab_t    Thr      = thr_table(F);

  logic has_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_alpha_q <= 1'b1;
    end else if (cfg_we_i) begin
      has_alpha_q <= cfg_wdata_i;
    end
  end

  logic     d_valid [DivCells+1];
  logic     d_ready [DivCells+1];
  div_pix_t d_data  [DivCells+1];

  hptm_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .bits_i  ({alpha_bits_i, blue_bits_i, green_bits_i, red_bits_i}),
    .valid_o (d_valid[0]),
    .ready_i (d_ready[0]),
    .data_o  (d_data[0])
  );

  for (genvar i = 0; i < DivCells; i++) begin : g_div
    hptm_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d_valid[i]),
      .ready_o (d_ready[i]),
      .data_i  (d_data[i]),
      .valid_o (d_valid[i+1]),
      .ready_i (d_ready[i+1]),
      .data_o  (d_data[i+1])
    );
  end

  logic      s_valid [9];
  logic      s_ready [9];
  srch_pix_t s_data  [9];

  // Round the quotient half up; special cases force M to zero or to one.
  always_comb begin
    logic [F+1:0] qr;
    for (int c = 0; c < NumCh; c++) begin
      qr = (F+2)'(d_data[DivCells][c].q[F:0]) + (F+2)'(1);
      s_data[0][c].k = 8'd0;
      if (d_data[DivCells][c].zero) s_data[0][c].m = '0;
      else if (d_data[DivCells][c].full) s_data[0][c].m = MaxMW'(1) << F;
      else s_data[0][c].m = MaxMW'(qr[F+1:1]);
    end
  end

  assign s_valid[0]        = d_valid[DivCells];
  assign d_ready[DivCells] = s_ready[0];

  for (genvar s = 0; s < 8; s++) begin : g_srch
    hptm_search_cell #(
      .Step (128 >> s),
      .Thr  (Thr)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (s_valid[s]),
      .ready_o (s_ready[s]),
      .data_i  (s_data[s]),
      .valid_o (s_valid[s+1]),
      .ready_i (s_ready[s+1]),
      .data_o  (s_data[s+1])
    );
  end

  assign s_ready[8]  = out_ready_i;
  assign out_valid_o = s_valid[8];
  assign red_out_o   = s_data[8][0].k;
  assign green_out_o = s_data[8][1].k;
  assign blue_out_o  = s_data[8][2].k;
  assign alpha_out_o = has_alpha_q ? s_data[8][3].k : 8'd255;

endmodule
`default_nettype wire

// ===== sv/hptm_checker.sv =====
`default_nettype none
module hptm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       cfg_we_i,
  input wire logic       cfg_wdata_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] red_out_o,
  input wire logic [7:0] green_out_o,
  input wire logic [7:0] blue_out_o,
  input wire logic [7:0] alpha_out_o
);

  logic ha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ha_q <= 1'b1;
    end else if (cfg_we_i) begin
      ha_q <= cfg_wdata_i;
    end
  end

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o) &&
    $stable(green_out_o) && $stable(blue_out_o) && $stable(alpha_out_o))
    else $error("stalled output item changed");

  a_alpha_forced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ha_q |-> alpha_out_o == 8'd255)
    else $error("alpha not forced with alpha disabled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready while output register empty");

endmodule

bind hdr_pixel_tone_map hptm_checker u_hptm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_out_o   (red_out_o),
  .green_out_o (green_out_o),
  .blue_out_o  (blue_out_o),
  .alpha_out_o (alpha_out_o)
);
`default_nettype wire
